// ----- rtl/rbb_pkg.sv -----
// Shared types and constants for the RGB 3x3 box blur.
package rbb_pkg;

    localparam int NUM_CH        = 3;
    localparam int CH_W          = 8;
    localparam int SUM_W         = 12;       // 9 * 255 fits in 12 bits
    localparam int DIV9_RECIP_W  = 13;
    localparam int DIV9_SHIFT    = 16;
    localparam logic [DIV9_RECIP_W-1:0] DIV9_RECIP = 13'd7282; // ceil(2^16 / 9)

    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // channel 0 red, 1 green, 2 blue
    typedef logic [NUM_CH-1:0][CH_W-1:0] rbb_pixel_t;

    typedef struct packed {
        rbb_pixel_t upper;
        rbb_pixel_t middle;
    } rbb_line_pair_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic eof;
    } rbb_flags_t;

endpackage

// ----- rtl/rbb_line_store.sv -----
// Paired upper/middle line store: one write port, one registered read port.
module rbb_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output rbb_pkg::rbb_line_pair_t      rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  rbb_pkg::rbb_line_pair_t      wr_data
);

    rbb_pkg::rbb_line_pair_t line_mem_reg [DEPTH];
    rbb_pkg::rbb_line_pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem_reg[wr_addr] <= wr_data;
        end
    end

    // same-address write forwards to the read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= line_mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rbb_div9.sv -----
// Divide a nine-sample sum by 9 via reciprocal multiply (exact for sums up to 2295).
module rbb_div9 (
    input  logic [rbb_pkg::SUM_W-1:0] sum,
    output logic [rbb_pkg::CH_W-1:0]  quotient
);

    localparam int PROD_W = rbb_pkg::SUM_W + rbb_pkg::DIV9_RECIP_W;

    logic [PROD_W-1:0] prod;

    assign prod     = PROD_W'(sum) * PROD_W'(rbb_pkg::DIV9_RECIP);
    assign quotient = prod[rbb_pkg::DIV9_SHIFT +: rbb_pkg::CH_W];

endmodule

// ----- rtl/rgb_box_blur_3x3.sv -----
// Top level of the streaming RGB 3x3 box blur.
//
// Usage:
//   Input channel (s_*): one word per pixel of a frame in raster order,
//   or a flush word (s_flush = 1) that carries no pixel. After the last
//   pixel of a frame send image_width + 1 flush words to drain the tail.
//   Result channel (m_*): one word per pixel position, centre of the
//   3x3 window; interior pixels get the per-channel mean of nine, border
//   pixels pass through. m_end_of_frame marks the frame's last word.
//   Configuration: cfg_wr_en/cfg_index/cfg_data write image_width
//   (index 0) or image_height (index 1) while the block is idle; values
//   are clamped to 3..MAX and any write restarts the frame.
// Timing:
//   Result of a pixel appears one row plus one pixel of input words
//   later; the word that completes a window passes the line-store read,
//   window, sum and divide-by-9 stages before it shows on m_*.
//   Throughput one word per cycle when m_ready holds (single-port-pair line store).
// Reset: pipeline empties, counters and window clear, sizes 640 x 480.
//   Line stores are not cleared. Stalls: a held result on m_* does not
//   block s_ready while pipeline bubbles remain; the stages then hold.
module rgb_box_blur_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [rbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input words
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rbb_pkg::CH_W-1:0]           s_in_red,
    input  logic [rbb_pkg::CH_W-1:0]           s_in_green,
    input  logic [rbb_pkg::CH_W-1:0]           s_in_blue,
    input  logic                               s_flush,
    // result words
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rbb_pkg::CH_W-1:0]           m_out_red,
    output logic [rbb_pkg::CH_W-1:0]           m_out_green,
    output logic [rbb_pkg::CH_W-1:0]           m_out_blue,
    output logic                               m_end_of_frame
);

    localparam int AW    = $clog2(MAX_WIDTH);       // column index
    localparam int WW    = $clog2(MAX_WIDTH + 1);   // width value
    localparam int HW    = $clog2(MAX_HEIGHT + 1);  // height value
    localparam int RW    = $clog2(MAX_HEIGHT + 2);  // row counter runs to h + 1
    localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    // ---------------- configuration ----------------
    logic [WW-1:0] eff_w_reg, eff_w_next;
    logic [HW-1:0] eff_h_reg, eff_h_next;
    logic [31:0]   w_raw, h_raw, w_clamp, h_clamp;
    logic          cfg_hit;

    always_comb begin
        w_raw = 32'(cfg_data[rbb_pkg::IMAGE_WIDTH_W-1:0]);
        h_raw = 32'(cfg_data[rbb_pkg::IMAGE_HEIGHT_W-1:0]);
        if (w_raw < 32'd3) begin
            w_clamp = 32'd3;
        end else if (w_raw > 32'(MAX_WIDTH)) begin
            w_clamp = 32'(MAX_WIDTH);
        end else begin
            w_clamp = w_raw;
        end
        if (h_raw < 32'd3) begin
            h_clamp = 32'd3;
        end else if (h_raw > 32'(MAX_HEIGHT)) begin
            h_clamp = 32'(MAX_HEIGHT);
        end else begin
            h_clamp = h_raw;
        end
        eff_w_next = eff_w_reg;
        eff_h_next = eff_h_reg;
        cfg_hit    = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                rbb_pkg::REG_IMAGE_WIDTH: begin
                    eff_w_next = WW'(w_clamp);
                    cfg_hit    = 1'b1;
                end
                rbb_pkg::REG_IMAGE_HEIGHT: begin
                    eff_h_next = HW'(h_clamp);
                    cfg_hit    = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg <= WW'(W_RST);
            eff_h_reg <= HW'(H_RST);
        end else begin
            eff_w_reg <= eff_w_next;
            eff_h_reg <= eff_h_next;
        end
    end

    // ---------------- stall chain ----------------
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic adv1, adv2, adv3, s_accept;

    assign adv3     = !m_valid_reg || m_ready;
    assign adv2     = !v3_reg || adv3;
    assign adv1     = !v2_reg || adv2;
    assign s_ready  = !v1_reg || adv1;
    assign s_accept = s_valid && s_ready;

    // ---------------- raster position (input side) ----------------
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] w_m1;
    logic [AW-1:0] w_last, ccol;
    logic [RW-1:0] h_ext, crow;
    logic          col_zero, col_last, draining;
    rbb_pkg::rbb_flags_t flags0;
    rbb_pkg::rbb_pixel_t pix0;

    always_comb begin
        w_m1     = eff_w_reg - WW'(1);
        w_last   = w_m1[AW-1:0];
        h_ext    = RW'(eff_h_reg);
        col_zero = (col_reg == '0);
        col_last = (col_reg == w_last);
        draining = (row_reg >= h_ext);

        ccol = col_zero ? w_last : col_reg - AW'(1);
        crow = col_zero ? row_reg - RW'(2) : row_reg - RW'(1);

        // nothing leaves until one row plus one pixel has gone in
        flags0.emit     = !((row_reg == '0) || ((row_reg == RW'(1)) && col_zero));
        flags0.interior = (crow != '0) && (crow <= h_ext - RW'(2))
                       && (ccol != '0) && (ccol <= w_last - AW'(1));
        flags0.eof      = (crow == h_ext - RW'(1)) && (ccol == w_last);

        // flush, or any word after the frame's last pixel, feeds zeros
        if (s_flush || draining) begin
            pix0 = '0;
        end else begin
            pix0 = {s_in_blue, s_in_green, s_in_red};
        end

        if (col_last) begin
            col_next = '0;
            row_next = row_reg + RW'(1);
        end else begin
            col_next = col_reg + AW'(1);
            row_next = row_reg;
        end
        if (flags0.emit && flags0.eof) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_hit) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: line store read ----------------
    rbb_pkg::rbb_pixel_t     pix1_reg;
    logic [AW-1:0]           addr1_reg;
    rbb_pkg::rbb_flags_t     flags1_reg;
    rbb_pkg::rbb_line_pair_t lines_rd, lines_wr;
    logic                    lines_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_accept) begin
            v1_reg <= 1'b1;
        end else if (adv1) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix1_reg   <= pix0;
            addr1_reg  <= col_reg;
            flags1_reg <= flags0;
        end
    end

    assign lines_we        = v1_reg && adv1;
    assign lines_wr.upper  = lines_rd.middle;
    assign lines_wr.middle = pix1_reg;

    rbb_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (lines_rd),
        .wr_en   (lines_we),
        .wr_addr (addr1_reg),
        .wr_data (lines_wr)
    );

    // ---------------- stage 2: 3x3 window ----------------
    rbb_pkg::rbb_pixel_t window_reg [3][3];
    rbb_pkg::rbb_flags_t flags2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    window_reg[r][c] <= '0;
                end
            end
        end else if (lines_we) begin
            for (int r = 0; r < 3; r++) begin
                window_reg[r][0] <= window_reg[r][1];
                window_reg[r][1] <= window_reg[r][2];
            end
            window_reg[0][2] <= lines_rd.upper;
            window_reg[1][2] <= lines_rd.middle;
            window_reg[2][2] <= pix1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (lines_we) begin
            v2_reg <= 1'b1;
        end else if (adv2) begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (lines_we) begin
            flags2_reg <= flags1_reg;
        end
    end

    // ---------------- stage 3: channel sums ----------------
    logic [rbb_pkg::SUM_W-1:0] sum2      [rbb_pkg::NUM_CH];
    logic [rbb_pkg::SUM_W-1:0] sum3_reg  [rbb_pkg::NUM_CH];
    rbb_pkg::rbb_pixel_t       centre3_reg;
    rbb_pkg::rbb_flags_t       flags3_reg;
    logic                      load3;

    always_comb begin
        for (int ch = 0; ch < rbb_pkg::NUM_CH; ch++) begin
            sum2[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    sum2[ch] = sum2[ch] + rbb_pkg::SUM_W'(window_reg[r][c][ch]);
                end
            end
        end
    end

    assign load3 = v2_reg && adv2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (load3) begin
            v3_reg <= 1'b1;
        end else if (adv3) begin
            v3_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load3) begin
            sum3_reg    <= sum2;
            centre3_reg <= window_reg[1][1];
            flags3_reg  <= flags2_reg;
        end
    end

    // ---------------- stage 4: divide by 9, output register ----------------
    rbb_pkg::rbb_pixel_t mean3, out_pix_reg;
    logic                eof_out_reg;
    logic                load_out;

    for (genvar ch = 0; ch < rbb_pkg::NUM_CH; ch++) begin : g_div
        rbb_div9 u_div9 (
            .sum      (sum3_reg[ch]),
            .quotient (mean3[ch])
        );
    end

    assign load_out = v3_reg && flags3_reg.emit && adv3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv3) begin
            m_valid_reg <= v3_reg && flags3_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_pix_reg <= flags3_reg.interior ? mean3 : centre3_reg;
            eof_out_reg <= flags3_reg.eof;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_red      = out_pix_reg[0];
    assign m_out_green    = out_pix_reg[1];
    assign m_out_blue     = out_pix_reg[2];
    assign m_end_of_frame = eof_out_reg;

endmodule

// ----- rtl/rbb_checker.sv -----
// Port-level checks for the RGB box blur, bound to the top level.
module rbb_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [rbb_pkg::CH_W-1:0] m_out_red,
    input logic [rbb_pkg::CH_W-1:0] m_out_green,
    input logic [rbb_pkg::CH_W-1:0] m_out_blue,
    input logic                     m_end_of_frame
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_out_green)
            && $stable(m_out_blue) && $stable(m_end_of_frame))
        else $error("result word changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty output register never back-pressures the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a draining receiver never stalls the input
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while receiver ready");

    // two frame ends never come in consecutive result words
    a_eof_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_end_of_frame |=> !(m_valid && m_end_of_frame))
        else $error("frame end repeated");

endmodule

bind rgb_box_blur_3x3 rbb_checker u_rbb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_red      (m_out_red),
    .m_out_green    (m_out_green),
    .m_out_blue     (m_out_blue),
    .m_end_of_frame (m_end_of_frame)
);

// ----- tb/blur_check.sv -----
// Checker for the RGB 3x3 box blur: predicts each result word and compares it.
`timescale 1ns / 1ps

module blur_check #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [rbb_pkg::CH_W-1:0]           s_in_red,
    input  logic [rbb_pkg::CH_W-1:0]           s_in_green,
    input  logic [rbb_pkg::CH_W-1:0]           s_in_blue,
    input  logic                               s_flush,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [rbb_pkg::CH_W-1:0]           m_out_red,
    input  logic [rbb_pkg::CH_W-1:0]           m_out_green,
    input  logic [rbb_pkg::CH_W-1:0]           m_out_blue,
    input  logic                               m_end_of_frame,
    output int                                 fail_count,
    output int                                 pending_count
);

    localparam int WINDOW_TAPS = 9;

    typedef struct packed {
        logic [rbb_pkg::CH_W-1:0] red;
        logic [rbb_pkg::CH_W-1:0] green;
        logic [rbb_pkg::CH_W-1:0] blue;
        logic                     eof;
    } blur_word_t;

    logic [rbb_pkg::IMAGE_WIDTH_W-1:0]  width_reg;
    logic [rbb_pkg::IMAGE_HEIGHT_W-1:0] height_reg;
    rbb_pkg::rbb_pixel_t                upper_row [MAX_WIDTH];
    rbb_pkg::rbb_pixel_t                middle_row [MAX_WIDTH];
    rbb_pkg::rbb_pixel_t                win [3][3];
    int unsigned                        col_pos;
    int unsigned                        row_pos;
    blur_word_t                         due_pixels [$];
    blur_word_t                         next_w;
    blur_word_t                         want_w;

    function automatic void restart_frame();
        foreach (win[r, c]) win[r][c] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // Advance the window by one input word; returns 1 when a result word is due.
    function automatic bit blur_next(input rbb_pkg::rbb_pixel_t px_in, input logic flush,
                                     output blur_word_t res);
        int unsigned         w, h, col, row, crow, ccol;
        int unsigned         sum [rbb_pkg::NUM_CH];
        rbb_pkg::rbb_pixel_t px;
        bit                  inner, last;
        w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        col = col_pos;
        row = row_pos;
        res = '0;
        if (col >= w) col = w - 1;
        // flush words and anything past the last row carry a zero pixel
        px = (!flush && row < h) ? px_in : '0;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = upper_row[col];
        win[1][2] = middle_row[col];
        win[2][2] = px;
        upper_row[col] = middle_row[col];
        middle_row[col] = px;
        col_pos = col + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
        end
        if (row == 0 || (row == 1 && col == 0))
            return 0;
        // centre of the window sits one row and one pixel behind
        crow = (col == 0) ? row - 2 : row - 1;
        ccol = (col == 0) ? w - 1 : col - 1;
        inner = crow >= 1 && crow + 2 <= h && ccol >= 1 && ccol + 2 <= w;
        last = (crow + 1 == h) && (ccol + 1 == w);
        foreach (sum[ch]) sum[ch] = 0;
        foreach (win[r, c])
            for (int ch = 0; ch < rbb_pkg::NUM_CH; ch++)
                sum[ch] += win[r][c][ch];
        if (inner) begin
            res.red   = rbb_pkg::CH_W'(sum[0] / WINDOW_TAPS);
            res.green = rbb_pkg::CH_W'(sum[1] / WINDOW_TAPS);
            res.blue  = rbb_pkg::CH_W'(sum[2] / WINDOW_TAPS);
        end else begin
            res.red   = win[1][1][0];
            res.green = win[1][1][1];
            res.blue  = win[1][1][2];
        end
        res.eof = last;
        if (last) begin
            col_pos = 0;
            row_pos = 0;
        end
        return 1;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [rbb_pkg::CH_W-1:0] want,
                                        input logic [rbb_pkg::CH_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg = 11'd640;
            height_reg = 13'd480;
            foreach (upper_row[i]) upper_row[i] = '0;
            foreach (middle_row[i]) middle_row[i] = '0;
            restart_frame();
            due_pixels.delete();
            fail_count = 0;
        end else begin
            // result side first: a word accepted now never stems from this edge's input
            if (m_valid && m_ready) begin
                if (due_pixels.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want_w = due_pixels.pop_front();
                    check_field("out_red", want_w.red, m_out_red);
                    check_field("out_green", want_w.green, m_out_green);
                    check_field("out_blue", want_w.blue, m_out_blue);
                    check_field("end_of_frame", rbb_pkg::CH_W'(want_w.eof),
                                rbb_pkg::CH_W'(m_end_of_frame));
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == rbb_pkg::REG_IMAGE_WIDTH)
                    width_reg = cfg_data[rbb_pkg::IMAGE_WIDTH_W-1:0];
                else if (cfg_index == rbb_pkg::REG_IMAGE_HEIGHT)
                    height_reg = cfg_data[rbb_pkg::IMAGE_HEIGHT_W-1:0];
                restart_frame();
            end
            if (s_valid && s_ready) begin
                if (blur_next({s_in_blue, s_in_green, s_in_red}, s_flush, next_w))
                    due_pixels.push_back(next_w);
            end
        end
        pending_count = due_pixels.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the RGB 3x3 box blur testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 4096;
    localparam int QUIET_LIMIT     = 2000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES     = 200;   // long receiver hold-off
    localparam int SETTLE_CYCLES   = 8;     // margin for tail words in the pipeline
    localparam int RANDOM_PER_MODE = 150;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [rbb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rbb_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [rbb_pkg::CH_W-1:0]        s_in_red = '0;
    logic [rbb_pkg::CH_W-1:0]        s_in_green = '0;
    logic [rbb_pkg::CH_W-1:0]        s_in_blue = '0;
    logic                            s_flush = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [rbb_pkg::CH_W-1:0]        m_out_red;
    logic [rbb_pkg::CH_W-1:0]        m_out_green;
    logic [rbb_pkg::CH_W-1:0]        m_out_blue;
    logic                            m_end_of_frame;

    int fail_count;
    int pending_count;
    int send_idle = 0;      // percent of cycles the sender holds back
    int recv_idle = 0;      // percent of cycles the receiver stalls
    bit hold_req = 1'b0;    // asks the receiver for one long hold-off
    int words_sent = 0;
    int quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rgb_box_blur_3x3 #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_red       (s_in_red),
        .s_in_green     (s_in_green),
        .s_in_blue      (s_in_blue),
        .s_flush        (s_flush),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_end_of_frame (m_end_of_frame)
    );

    blur_check #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_blur_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_red       (s_in_red),
        .s_in_green     (s_in_green),
        .s_in_blue      (s_in_blue),
        .s_flush        (s_flush),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_end_of_frame (m_end_of_frame),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // Watchdog: ends the run if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL rgb_box_blur_3x3");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    // The hold is counted here so the sender keeps offering words meanwhile.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready = ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one word; entered and left at a falling edge. Valid is only
    // lowered when an idle cycle is actually taken, never just to re-raise it.
    task automatic send_word(input logic [rbb_pkg::CH_W-1:0] r,
                             input logic [rbb_pkg::CH_W-1:0] g,
                             input logic [rbb_pkg::CH_W-1:0] b, input logic fl);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_in_red = r;
        s_in_green = g;
        s_in_blue = b;
        s_flush = fl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    // Wait for every due word, then let any word that yields no result clear the pipe.
    task automatic settle();
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write both size registers while idle; each write restarts the frame.
    task automatic set_size(input logic [rbb_pkg::CFG_DATA_W-1:0] w_raw,
                            input logic [rbb_pkg::CFG_DATA_W-1:0] h_raw);
        settle();
        cfg_wr_en = 1'b1;
        cfg_index = rbb_pkg::REG_IMAGE_WIDTH;
        cfg_data = w_raw;
        @(negedge aclk);
        cfg_index = rbb_pkg::REG_IMAGE_HEIGHT;
        cfg_data = h_raw;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // One frame of random pixels then its drain; cut > 0 abandons it after
    // that many words, leaving the next size write to restart the frame.
    task automatic run_frame(input int w, input int h, input int cut);
        for (int i = 0; i < w * h; i++) begin
            if (cut != 0 && i == cut)
                return;
            // the odd flush mid-frame stands for a black pixel
            send_word(rbb_pkg::CH_W'($urandom), rbb_pkg::CH_W'($urandom),
                      rbb_pkg::CH_W'($urandom), $urandom_range(99) < 4);
        end
        // drain: pixels here are treated as flush words
        for (int i = 0; i <= w; i++)
            send_word(rbb_pkg::CH_W'($urandom), rbb_pkg::CH_W'($urandom),
                      rbb_pkg::CH_W'($urandom), 1'($urandom_range(1)));
    endtask

    initial begin
        int w, h, mode_start;

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: 3x3 frames via clamped sizes (0 -> 3 wide, 2 -> 3 high).
        set_size(13'd0, 13'd2);
        // first frame: flush word standing in for a pixel, mixed extremes
        for (int i = 0; i < 9; i++) begin
            if (i == 2)
                send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);
            else
                send_word(i[0] ? 8'hFF : 8'h00, rbb_pkg::CH_W'(i * 29),
                          8'hFF - rbb_pkg::CH_W'(i * 17), 1'b0);
        end
        // drain mixing flush words and pixels, which must not show up
        send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_word(8'h00, 8'h00, 8'h00, 1'b1);
        send_word(8'hAA, 8'h55, 8'hFF, 1'b0);
        send_word(8'h00, 8'h00, 8'h00, 1'b1);
        // second frame follows straight on: full-scale sum for the centre
        repeat (9) send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
        repeat (4) send_word(8'h00, 8'h00, 8'h00, 1'b1);

        // Random frames under three idling patterns.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle = 16;
                    recv_idle = 74;
                end
                1: begin
                    send_idle = 74;
                    recv_idle = 16;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            mode_start = words_sent;
            while (words_sent - mode_start < RANDOM_PER_MODE) begin
                w = $urandom_range(3, 12);
                h = $urandom_range(3, 8);
                set_size(rbb_pkg::CFG_DATA_W'(w), rbb_pkg::CFG_DATA_W'(h));
                if ($urandom_range(9) == 0)
                    run_frame(w, h, $urandom_range(1, w * h - 1));
                else
                    repeat ($urandom_range(1, 2)) run_frame(w, h, 0);
                // stray words after a frame shift the next one out of step
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word(rbb_pkg::CH_W'($urandom), rbb_pkg::CH_W'($urandom),
                                  rbb_pkg::CH_W'($urandom), 1'($urandom_range(1)));
            end
        end

        // Receiver holds off while words keep coming, so the input must stall.
        set_size(13'd10, 13'd8);
        hold_req = 1'b1;
        run_frame(10, 8, 0);

        // Width field is 11 bits: the upper data bits drop away, leaving 3.
        set_size(13'h1803, 13'd3);
        run_frame(3, 3, 0);
        // All-ones height clamps to MAX_HEIGHT; the tall frame is only
        // started, then abandoned.
        set_size(13'd3, 13'h1FFF);
        run_frame(3, MAX_HEIGHT, 60);

        settle();
        if (fail_count == 0)
            $display("PASS rgb_box_blur_3x3");
        else
            $display("FAIL rgb_box_blur_3x3");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rbb_pkg.sv
rtl/rbb_line_store.sv
rtl/rbb_div9.sv
rtl/rgb_box_blur_3x3.sv
rtl/rbb_checker.sv
tb/blur_check.sv
tb/testbench.sv
